// File: rtl/core/nested_zone_profiler_core_macros.svh
// ----------------------------------------------------------------------------
// nested zone profiler assertion macros
// clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef NESTED_ZONE_PROFILER_CORE_MACROS_SVH
`define NESTED_ZONE_PROFILER_CORE_MACROS_SVH

// same-cycle implication
`define NZP_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication
`define NZP_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// File: rtl/core/nzp_pkg.sv
// ----------------------------------------------------------------------------
// nzp_pkg
// types and codes shared by the nested zone profiler modules
// ----------------------------------------------------------------------------
package nzp_pkg;

  // zone numbers arrive on a 5-bit field
  localparam int ZONE_IDS = 32;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ENTER = 2'd0;
  localparam kind_t KIND_EXIT  = 2'd1;
  localparam kind_t KIND_READ  = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // decoded operation carried down the pipeline
  typedef enum logic [1:0] {
    OP_ENTER,
    OP_EXIT,
    OP_REPORT,
    OP_EMPTY
  } op_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  zone_id;
    logic [63:0] timestamp;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] hit_count;
    logic [63:0] excl_time;
    logic [63:0] incl_time;
    logic [7:0]  active_count;
    logic [7:0]  stack_depth;
  } out_item_t;

  typedef struct packed {
    logic [31:0] hits;
    logic [7:0]  active;
    logic [63:0] total;
  } zone_rec_t;

  // stage after the stack read
  typedef struct packed {
    op_t         op;
    status_t     status;
    logic [63:0] ts;
    logic [63:0] start;
    logic        has_parent;
    logic [7:0]  depth;
  } s1_t;

  // stage after the zone table read
  typedef struct packed {
    op_t         op;
    status_t     status;
    logic [63:0] dur;
    logic        has_parent;
    logic [7:0]  depth;
  } s2_t;

  // table writes: record and own time at the zone, child time at the parent
  typedef struct packed {
    logic        rec_we;
    logic        inc_we;
    logic        dec_we;
    zone_rec_t   rec;
    logic [63:0] inc;
    logic [63:0] dec;
  } zone_wr_t;

  typedef struct packed {
    zone_rec_t   rec;
    logic [63:0] inc;
    logic [63:0] dec_zone;
    logic [63:0] dec_parent;
  } zone_cur_t;

endpackage

// File: rtl/core/nested_zone_profiler_core.sv
// ----------------------------------------------------------------------------
// nested_zone_profiler_core
// enter, exit and read events against a stack of open zones and a per-zone
// counter table
// ----------------------------------------------------------------------------
// Takes one event per cycle while in_stall is low and returns one result per
// event. The top and parent entries of the open-zone stack are read into the
// first stage register as the item is taken, the zone table is then read at
// the affected zone and its parent into the second stage register, and as
// the item moves into the output register the duration is added, the table
// written back and the result loaded; a write that lands on the edge of the
// following read is bypassed, so back-to-back events on the same zone keep
// full rate. The counter table is zero right after reset with no clearing
// pass. Enter on a full stack reports status 1 and changes nothing; exit on
// an empty stack reports status 2 with zero counters.
module nested_zone_profiler_core #(
  parameter int ZONES = 32,
  parameter int STACK_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  nzp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output nzp_pkg::out_item_t out_data
);
  import nzp_pkg::*;

  localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;

  logic          en_out;
  logic          en2;
  logic          en1;
  logic          acc;
  logic          wr_go;

  logic          s1_valid;
  s1_t           s1;
  logic [ZW-1:0] s1_zone;
  logic [ZW-1:0] s1_parent;

  logic          s2_valid;
  s2_t           s2;
  logic [ZW-1:0] s2_zone;
  logic [ZW-1:0] s2_parent;

  zone_cur_t     cur;
  zone_wr_t      wr_calc;
  zone_wr_t      wr;
  out_item_t     res;

  // each stage moves when the one after it is empty or moving
  always_comb begin
    en_out   = !out_valid || !out_stall;
    en2      = !s2_valid || en_out;
    en1      = !s1_valid || en2;
    in_stall = !en1;
    acc      = in_valid && en1;
    wr_go    = s2_valid && en_out;
  end

  nzp_stack #(
    .ZONES       (ZONES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .ld        (en1),
    .item      (in_data),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .s1_zone   (s1_zone),
    .s1_parent (s1_parent)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2.op         <= s1.op;
      s2.status     <= s1.status;
      s2.dur        <= s1.ts - s1.start;
      s2.has_parent <= s1.has_parent;
      s2.depth      <= s1.depth;
      s2_zone       <= s1_zone;
      s2_parent     <= s1_parent;
    end
  end

  nzp_table #(
    .ZONES (ZONES)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (en2),
    .rd_zone   (s1_zone),
    .rd_parent (s1_parent),
    .wr        (wr),
    .wr_zone   (s2_zone),
    .wr_parent (s2_parent),
    .cur       (cur)
  );

  nzp_calc u_calc (
    .s2        (s2),
    .same_zone (s2_zone == s2_parent),
    .cur       (cur),
    .wr        (wr_calc),
    .res       (res)
  );

  // table is written only as the item leaves for the output register
  always_comb begin
    wr        = wr_calc;
    wr.rec_we = wr_calc.rec_we && wr_go;
    wr.inc_we = wr_calc.inc_we && wr_go;
    wr.dec_we = wr_calc.dec_we && wr_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      out_data <= res;
    end
  end

endmodule

// File: rtl/core/nzp_stack.sv
// ----------------------------------------------------------------------------
// nzp_stack
// open zone stack, depth counter, event decode and the first pipeline stage
// ----------------------------------------------------------------------------
`include "nested_zone_profiler_core_macros.svh"

module nzp_stack #(
  parameter int ZONES = 32,
  parameter int STACK_DEPTH = 128,
  localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             acc,
  input  logic             ld,
  input  nzp_pkg::in_item_t item,
  output logic             s1_valid,
  output nzp_pkg::s1_t     s1,
  output logic [ZW-1:0]    s1_zone,
  output logic [ZW-1:0]    s1_parent
);
  import nzp_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int SW = $clog2(STACK_DEPTH);

  function automatic logic [ZONE_IDS*ZW-1:0] build_zmap();
    logic [ZONE_IDS*ZW-1:0] m;
    m = '0;
    for (int i = 0; i < ZONE_IDS; i++) begin
      m[i*ZW +: ZW] = ZW'(i % ZONES);
    end
    return m;
  endfunction

  // zone number to table address
  localparam logic [ZONE_IDS*ZW-1:0] ZMAP = build_zmap();

  logic [DW-1:0] depth;
  logic [DW-1:0] depth_next;
  logic [DW-1:0] top_cnt;
  logic [DW-1:0] par_cnt;
  logic [ZW-1:0] zid_map;
  logic          push;
  logic          pop;
  logic          has_parent;
  op_t           op;
  status_t       status;

  logic [ZW-1:0] ids [STACK_DEPTH];
  logic [63:0]   starts [STACK_DEPTH];

  logic [ZW-1:0] top_id;
  logic [ZW-1:0] par_id;
  logic [ZW-1:0] zid_q;
  logic [63:0]   start_q;
  logic [63:0]   ts_q;
  op_t           op_q;
  status_t       status_q;
  logic          hp_q;
  logic [7:0]    depth_q;

  always_comb begin
    zid_map = ZMAP[item.zone_id*ZW +: ZW];
    push    = 1'b0;
    pop     = 1'b0;
    op      = OP_REPORT;
    status  = ST_OK;
    unique case (item.kind)
      KIND_ENTER: begin
        if (depth == DW'(STACK_DEPTH)) begin
          status = ST_FULL;
        end else begin
          op   = OP_ENTER;
          push = 1'b1;
        end
      end
      KIND_EXIT: begin
        if (depth == '0) begin
          op     = OP_EMPTY;
          status = ST_EMPTY;
        end else begin
          op  = OP_EXIT;
          pop = 1'b1;
        end
      end
      default: begin
        op = OP_REPORT;
      end
    endcase
  end

  always_comb begin
    if (push) begin
      depth_next = depth + DW'(1);
    end else if (pop) begin
      depth_next = depth - DW'(1);
    end else begin
      depth_next = depth;
    end
    has_parent = depth > DW'(1);
    top_cnt    = depth - DW'(1);
    par_cnt    = depth - DW'(2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (acc) begin
      depth <= depth_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && push) begin
      ids[depth[SW-1:0]]    <= zid_map;
      starts[depth[SW-1:0]] <= item.timestamp;
    end
  end

  // top and parent entries are read as the item is taken
  always_ff @(posedge clk) begin
    if (ld) begin
      top_id   <= ids[top_cnt[SW-1:0]];
      par_id   <= ids[par_cnt[SW-1:0]];
      start_q  <= starts[top_cnt[SW-1:0]];
      ts_q     <= item.timestamp;
      zid_q    <= zid_map;
      op_q     <= op;
      status_q <= status;
      hp_q     <= has_parent;
      depth_q  <= 8'(depth_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ld) begin
      s1_valid <= acc;
    end
  end

  always_comb begin
    s1.op         = op_q;
    s1.status     = status_q;
    s1.ts         = ts_q;
    s1.start      = start_q;
    s1.has_parent = hp_q;
    s1.depth      = depth_q;
    s1_zone       = (op_q == OP_EXIT) ? top_id : zid_q;
    s1_parent     = par_id;
  end

  `NZP_ASSERT_NOW(a_depth_bound, 1'b1, depth <= DW'(STACK_DEPTH), "stack depth out of range")
  `NZP_ASSERT_NEXT(a_push_depth, acc && push, depth == $past(depth) + DW'(1), "push lost")
  `NZP_ASSERT_NOW(a_full_depth, s1_valid && (s1.status == ST_FULL),
    s1.depth == 8'(STACK_DEPTH), "full status below full depth")

endmodule

// File: rtl/core/nzp_table.sv
// ----------------------------------------------------------------------------
// nzp_table
// per-zone counters: record, own time and child time, with a one-deep
// bypass for the write that lands on the read edge
// ----------------------------------------------------------------------------
`include "nested_zone_profiler_core_macros.svh"

module nzp_table #(
  parameter int ZONES = 32,
  localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [ZW-1:0]      rd_zone,
  input  logic [ZW-1:0]      rd_parent,
  input  nzp_pkg::zone_wr_t  wr,
  input  logic [ZW-1:0]      wr_zone,
  input  logic [ZW-1:0]      wr_parent,
  output nzp_pkg::zone_cur_t cur
);
  import nzp_pkg::*;

  zone_rec_t   rec_mem [ZONES];
  logic [63:0] inc_mem [ZONES];
  logic [63:0] dec_mem [ZONES];

  // entries never written read as zero
  logic [ZONES-1:0] rec_vld;
  logic [ZONES-1:0] inc_vld;
  logic [ZONES-1:0] dec_vld;

  zone_rec_t   rec_q;
  logic [63:0] inc_q;
  logic [63:0] deca_q;
  logic [63:0] decp_q;
  logic        rec_v_q;
  logic        inc_v_q;
  logic        deca_v_q;
  logic        decp_v_q;
  logic [ZW-1:0] zone_q;
  logic [ZW-1:0] parent_q;

  logic          f_rec_we;
  logic          f_inc_we;
  logic          f_dec_we;
  logic [ZW-1:0] f_zone;
  logic [ZW-1:0] f_parent;
  zone_rec_t     f_rec;
  logic [63:0]   f_inc;
  logic [63:0]   f_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_vld <= '0;
      inc_vld <= '0;
      dec_vld <= '0;
    end else begin
      if (wr.rec_we) begin
        rec_vld[wr_zone] <= 1'b1;
      end
      if (wr.inc_we) begin
        inc_vld[wr_zone] <= 1'b1;
      end
      if (wr.dec_we) begin
        dec_vld[wr_parent] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.rec_we) begin
      rec_mem[wr_zone] <= wr.rec;
    end
    if (wr.inc_we) begin
      inc_mem[wr_zone] <= wr.inc;
    end
    if (wr.dec_we) begin
      dec_mem[wr_parent] <= wr.dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rec_q    <= rec_mem[rd_zone];
      inc_q    <= inc_mem[rd_zone];
      deca_q   <= dec_mem[rd_zone];
      decp_q   <= dec_mem[rd_parent];
      rec_v_q  <= rec_vld[rd_zone];
      inc_v_q  <= inc_vld[rd_zone];
      deca_v_q <= dec_vld[rd_zone];
      decp_v_q <= dec_vld[rd_parent];
      zone_q   <= rd_zone;
      parent_q <= rd_parent;
      f_zone   <= wr_zone;
      f_parent <= wr_parent;
      f_rec    <= wr.rec;
      f_inc    <= wr.inc;
      f_dec    <= wr.dec;
    end
  end

  // remember which writes the registered read missed
  always_ff @(posedge clk) begin
    if (rst) begin
      f_rec_we <= 1'b0;
      f_inc_we <= 1'b0;
      f_dec_we <= 1'b0;
    end else if (rd_en) begin
      f_rec_we <= wr.rec_we;
      f_inc_we <= wr.inc_we;
      f_dec_we <= wr.dec_we;
    end
  end

  always_comb begin
    if (f_rec_we && (f_zone == zone_q)) begin
      cur.rec = f_rec;
    end else begin
      cur.rec = rec_v_q ? rec_q : '0;
    end
    if (f_inc_we && (f_zone == zone_q)) begin
      cur.inc = f_inc;
    end else begin
      cur.inc = inc_v_q ? inc_q : '0;
    end
    if (f_dec_we && (f_parent == zone_q)) begin
      cur.dec_zone = f_dec;
    end else begin
      cur.dec_zone = deca_v_q ? deca_q : '0;
    end
    if (f_dec_we && (f_parent == parent_q)) begin
      cur.dec_parent = f_dec;
    end else begin
      cur.dec_parent = decp_v_q ? decp_q : '0;
    end
  end

  `NZP_ASSERT_NEXT(a_rec_valid, wr.rec_we, rec_vld[$past(wr_zone)], "record write not marked")
  `NZP_ASSERT_NEXT(a_dec_valid, wr.dec_we, dec_vld[$past(wr_parent)], "child time not marked")
  `NZP_ASSERT_NOW(a_wr_on_read, wr.rec_we || wr.inc_we || wr.dec_we, rd_en,
    "write on an edge with no read capture")

endmodule

// File: rtl/core/nzp_calc.sv
// ----------------------------------------------------------------------------
// nzp_calc
// counter update and result fields for the item in the second stage
// ----------------------------------------------------------------------------
module nzp_calc (
  input  nzp_pkg::s2_t       s2,
  input  logic               same_zone,
  input  nzp_pkg::zone_cur_t cur,
  output nzp_pkg::zone_wr_t  wr,
  output nzp_pkg::out_item_t res
);
  import nzp_pkg::*;

  zone_rec_t   rec_new;
  logic [63:0] own_add;

  always_comb begin
    rec_new   = cur.rec;
    own_add   = '0;
    wr.rec_we = 1'b0;
    wr.inc_we = 1'b0;
    wr.dec_we = 1'b0;
    case (s2.op)
      OP_ENTER: begin
        rec_new.hits   = cur.rec.hits + 32'd1;
        rec_new.active = cur.rec.active + 8'd1;
        wr.rec_we      = 1'b1;
      end
      OP_EXIT: begin
        rec_new.active = cur.rec.active - 8'd1;
        // only the outermost activation adds to total
        if (cur.rec.active == 8'd1) begin
          rec_new.total = cur.rec.total + s2.dur;
        end
        wr.rec_we = 1'b1;
        wr.inc_we = 1'b1;
        wr.dec_we = s2.has_parent;
        // a recursive parent of the same zone cancels the addition
        if (!(s2.has_parent && same_zone)) begin
          own_add = s2.dur;
        end
      end
      default: begin
        rec_new = cur.rec;
      end
    endcase
    wr.rec = rec_new;
    wr.inc = cur.inc + s2.dur;
    wr.dec = cur.dec_parent + s2.dur;
  end

  always_comb begin
    res.status      = s2.status;
    res.stack_depth = s2.depth;
    if (s2.op == OP_EMPTY) begin
      res.hit_count    = '0;
      res.excl_time    = '0;
      res.incl_time    = '0;
      res.active_count = '0;
    end else begin
      res.hit_count    = rec_new.hits;
      res.excl_time    = cur.inc - cur.dec_zone + own_add;
      res.incl_time    = rec_new.total;
      res.active_count = rec_new.active;
    end
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for nested_zone_profiler_core. Drives enter, exit and
// read events with random gaps on the input side and random stalls on the
// output side. A behavioral profiler in the bench keeps its own zone stack
// and counter table; each report is compared field by field against it or
// a script row's fixed value. Stimulus: a short scripted sequence, a fill of
// the whole zone stack with pushes past the top, then random nesting with noise.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nzp_pkg::*;

  localparam int ZONES      = 32;
  localparam int STACK      = 128;
  localparam int RAND_ITEMS = 120;
  localparam int CALM_ITEMS = 30;
  localparam int WATCHDOG   = 2000;
  localparam int DRAIN      = 20;

  // the fourth kind code is decoded as a read
  localparam kind_t KIND_SPARE = 2'd3;

  typedef struct packed {
    in_item_t  ev;
    logic      fixed;
    out_item_t want;
  } script_row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // behavioral profiler state
  logic [31:0] zone_hit_cnt  [ZONES];
  logic [63:0] zone_own_time [ZONES];
  logic [63:0] zone_span_time[ZONES];
  logic [7:0]  zone_nest     [ZONES];
  logic [4:0]  frame_zone    [STACK];
  logic [63:0] frame_start   [STACK];
  int          open_count;

  out_item_t   expected_reports[$];
  script_row_t script[$];
  out_item_t   head_report;
  int          mismatches;
  int          reports_seen;
  int          quiet_cycles;
  bit          idle_on;
  logic [63:0] clock_now;

  nested_zone_profiler_core #(
    .ZONES(ZONES),
    .STACK_DEPTH(STACK)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic out_item_t mk_report(input status_t st, input logic [31:0] hits,
                                          input logic [63:0] own, input logic [63:0] span,
                                          input logic [7:0] nest, input logic [7:0] depth);
    out_item_t r;
    r.status       = st;
    r.hit_count    = hits;
    r.excl_time    = own;
    r.incl_time    = span;
    r.active_count = nest;
    r.stack_depth  = depth;
    return r;
  endfunction

  function automatic in_item_t mk_event(input kind_t k, input logic [4:0] zone,
                                        input logic [63:0] stamp);
    in_item_t e;
    e.kind      = k;
    e.zone_id   = zone;
    e.timestamp = stamp;
    return e;
  endfunction

  // applies one event to the profiler state and returns its report
  function automatic out_item_t profile_event(input in_item_t ev);
    out_item_t   r;
    logic [4:0]  z;
    logic [4:0]  parent;
    logic [63:0] span;
    int          top;
    r = '0;
    z = ev.zone_id;
    if (ev.kind == KIND_EXIT) begin
      if (open_count == 0) begin
        r.status = ST_EMPTY;
        return r;
      end
      top  = open_count - 1;
      z    = frame_zone[top];
      span = ev.timestamp - frame_start[top];
      // only the outermost instance of a recursive zone adds to its total
      if (zone_nest[z] == 8'd1) zone_span_time[z] = zone_span_time[z] + span;
      zone_own_time[z] = zone_own_time[z] + span;
      if (open_count > 1) begin
        parent = frame_zone[top - 1];
        zone_own_time[parent] = zone_own_time[parent] - span;
      end
      zone_nest[z] = zone_nest[z] - 8'd1;
      open_count   = top;
      r.status     = ST_OK;
    end else if (ev.kind == KIND_ENTER) begin
      if (open_count >= STACK) begin
        r.status = ST_FULL;
      end else begin
        frame_zone[open_count]  = z;
        frame_start[open_count] = ev.timestamp;
        open_count++;
        zone_hit_cnt[z] = zone_hit_cnt[z] + 32'd1;
        zone_nest[z]    = zone_nest[z] + 8'd1;
        r.status        = ST_OK;
      end
    end else begin
      r.status = ST_OK;
    end
    r.hit_count    = zone_hit_cnt[z];
    r.excl_time    = zone_own_time[z];
    r.incl_time    = zone_span_time[z];
    r.active_count = zone_nest[z];
    r.stack_depth  = open_count[7:0];
    return r;
  endfunction

  function automatic logic [63:0] next_stamp();
    // mostly a slow counter, now and then a big jump that may wrap
    if ($urandom_range(0, 15) == 0) clock_now = clock_now + {$urandom, $urandom};
    else clock_now = clock_now + 64'($urandom_range(0, 300));
    return clock_now;
  endfunction

  task automatic add_row(input in_item_t ev, input logic fixed, input out_item_t want);
    script_row_t row;
    row.ev    = ev;
    row.fixed = fixed;
    row.want  = want;
    script.push_back(row);
  endtask

  task automatic run_event(input in_item_t ev, input logic fixed, input out_item_t want);
    out_item_t predicted;
    int        gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = profile_event(ev);
    expected_reports.push_back(fixed ? want : predicted);
  endtask

  task automatic note_mismatch(input string what, input out_item_t want,
                               input out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", what);
      $display("  expected: st %0d hits %h excl %h total %h act %0d depth %0d",
               want.status, want.hit_count, want.excl_time, want.incl_time,
               want.active_count, want.stack_depth);
      $display("  actual:   st %0d hits %h excl %h total %h act %0d depth %0d",
               got.status, got.hit_count, got.excl_time, got.incl_time,
               got.active_count, got.stack_depth);
    end
  endtask

  // report checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        note_mismatch($sformatf("report %0d arrived with nothing pending", reports_seen),
                      '0, out_data);
      end else begin
        head_report = expected_reports.pop_front();
        if (out_data.status !== head_report.status ||
            out_data.hit_count !== head_report.hit_count ||
            out_data.excl_time !== head_report.excl_time ||
            out_data.incl_time !== head_report.incl_time ||
            out_data.active_count !== head_report.active_count ||
            out_data.stack_depth !== head_report.stack_depth) begin
          note_mismatch($sformatf("report %0d differs", reports_seen), head_report,
                        out_data);
        end
      end
    end
  end

  // output stall bursts
  initial begin
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ends the run when nothing moves on either side for too long
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [63:0] ones;
    out_item_t   none;
    kind_t       k;
    logic [4:0]  zone;
    int          pick;
    int          enter_w;
    ones = '1;
    none = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    idle_on = 1'b1;
    mismatches = 0;
    reports_seen = 0;
    open_count = 0;
    clock_now = {$urandom, $urandom};
    for (int i = 0; i < ZONES; i++) begin
      zone_hit_cnt[i]   = '0;
      zone_own_time[i]  = '0;
      zone_span_time[i] = '0;
      zone_nest[i]      = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // scripted events: empty pops, extremes, recursion, wrapping durations
    add_row(mk_event(KIND_EXIT, 5'd0, 64'd0), 1'b1,
            mk_report(ST_EMPTY, 32'd0, 64'd0, 64'd0, 8'd0, 8'd0));
    add_row(mk_event(KIND_READ, 5'd31, ones), 1'b1,
            mk_report(ST_OK, 32'd0, 64'd0, 64'd0, 8'd0, 8'd0));
    add_row(mk_event(KIND_ENTER, 5'd0, 64'd0), 1'b1,
            mk_report(ST_OK, 32'd1, 64'd0, 64'd0, 8'd1, 8'd1));
    add_row(mk_event(KIND_ENTER, 5'd31, 64'd100), 1'b1,
            mk_report(ST_OK, 32'd1, 64'd0, 64'd0, 8'd1, 8'd2));
    add_row(mk_event(KIND_EXIT, 5'd31, 64'd250), 1'b1,
            mk_report(ST_OK, 32'd1, 64'd150, 64'd150, 8'd0, 8'd1));
    add_row(mk_event(KIND_SPARE, 5'd0, 64'd260), 1'b0, none);
    add_row(mk_event(KIND_ENTER, 5'd0, 64'd300), 1'b0, none);
    add_row(mk_event(KIND_EXIT, 5'd7, 64'd400), 1'b0, none);
    add_row(mk_event(KIND_EXIT, 5'd0, ones), 1'b0, none);
    add_row(mk_event(KIND_EXIT, 5'd3, 64'd7), 1'b1,
            mk_report(ST_EMPTY, 32'd0, 64'd0, 64'd0, 8'd0, 8'd0));
    add_row(mk_event(KIND_ENTER, 5'd5, ones), 1'b0, none);
    add_row(mk_event(KIND_EXIT, 5'd5, 64'd5), 1'b0, none);
    add_row(mk_event(KIND_SPARE, 5'd5, 64'd6), 1'b0, none);
    add_row(mk_event(KIND_ENTER, 5'd21, 64'h5555_5555_5555_5555), 1'b0, none);
    add_row(mk_event(KIND_ENTER, 5'd10, 64'hAAAA_AAAA_AAAA_AAAA), 1'b0, none);
    add_row(mk_event(KIND_ENTER, 5'd21, 64'hAAAA_AAAA_AAAA_AAAD), 1'b0, none);
    add_row(mk_event(KIND_READ, 5'd21, 64'hAAAA_AAAA_AAAA_AAAE), 1'b0, none);
    add_row(mk_event(KIND_EXIT, 5'd0, 64'hAAAA_AAAA_AAAB_0000), 1'b0, none);
    add_row(mk_event(KIND_EXIT, 5'd0, 64'hAAAA_AAAA_AAAC_0000), 1'b0, none);
    add_row(mk_event(KIND_EXIT, 5'd0, 64'hFFFF_0000_0000_0000), 1'b0, none);
    add_row(mk_event(KIND_READ, 5'd10, 64'd0), 1'b0, none);
    foreach (script[i]) run_event(script[i].ev, script[i].fixed, script[i].want);

    // fill the zone stack, push past the top, then unwind it all
    while (open_count < STACK)
      run_event(mk_event(KIND_ENTER, 5'($urandom_range(0, 31)), next_stamp()), 1'b0, none);
    repeat (2)
      run_event(mk_event(KIND_ENTER, 5'($urandom_range(0, 31)), next_stamp()), 1'b0, none);
    run_event(mk_event(KIND_READ, 5'($urandom_range(0, 31)), next_stamp()), 1'b0, none);
    while (open_count > 0)
      run_event(mk_event(KIND_EXIT, 5'($urandom_range(0, 31)), next_stamp()), 1'b0, none);
    run_event(mk_event(KIND_EXIT, 5'($urandom_range(0, 31)), next_stamp()), 1'b0, none);

    // random nesting, mostly on a few zones so recursion is common
    for (int n = 0; n < RAND_ITEMS; n++) begin
      idle_on = (n < RAND_ITEMS - CALM_ITEMS) && ((n / 50) % 3 != 2);
      enter_w = (open_count < 3) ? 50 : (open_count > 24) ? 20 : 38;
      zone = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        run_event(mk_event(kind_t'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                           {$urandom, $urandom}), 1'b0, none);
      end else begin
        if (pick < 5 + enter_w) k = KIND_ENTER;
        else if (pick < 43 + enter_w) k = KIND_EXIT;
        else k = ($urandom_range(0, 3) == 0) ? KIND_SPARE : KIND_READ;
        run_event(mk_event(k, zone, next_stamp()), 1'b0, none);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/nzp_pkg.sv
rtl/core/nzp_stack.sv
rtl/core/nzp_table.sv
rtl/core/nzp_calc.sv
rtl/core/nested_zone_profiler_core.sv
tb/tb.sv
